[sv/rdm_pkg.sv]
// ----------------------------------------------------------------------------
// rdm_pkg: shared definitions of the drive mode controller
// Register indexes, reset values, command letters and result codes.
// ----------------------------------------------------------------------------
package rdm_pkg;

  localparam int unsigned LINE_SENSORS_DEF = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STOP_CM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_TRIG_CM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_MS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MS       = 3'd7;

  // Register reset values.
  localparam logic [7:0]  RST_BASE_SPEED    = 8'd140;
  localparam logic [15:0] RST_STEER_GAIN    = 16'd8960;
  localparam logic [7:0]  RST_MIN_SPEED     = 8'd90;
  localparam logic [7:0]  RST_MAX_SPEED     = 8'd255;
  localparam logic [9:0]  RST_LINE_STOP_CM  = 10'd25;
  localparam logic [9:0]  RST_AVOID_TRIG_CM = 10'd20;
  localparam logic [15:0] RST_BACKUP_MS     = 16'd400;
  localparam logic [15:0] RST_TURN_MS       = 16'd300;

  // Command letters, lower case.
  localparam logic [7:0] CMD_MANUAL = 8'h6D;  // m
  localparam logic [7:0] CMD_LINE   = 8'h76;  // v
  localparam logic [7:0] CMD_PROX   = 8'h70;  // p
  localparam logic [7:0] CMD_FWD    = 8'h66;  // f
  localparam logic [7:0] CMD_BACK   = 8'h62;  // b
  localparam logic [7:0] CMD_LEFT   = 8'h6C;  // l
  localparam logic [7:0] CMD_RIGHT  = 8'h72;  // r
  localparam logic [7:0] CMD_CLEAR  = 8'h78;  // x
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic KIND_CMD = 1'b0;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_STOP      = 4'd1,
    ACT_FWD       = 4'd2,
    ACT_BACK      = 4'd3,
    ACT_SPIN_L    = 4'd4,
    ACT_SPIN_R    = 4'd5,
    ACT_FWD_L     = 4'd6,
    ACT_FWD_R     = 4'd7,
    ACT_BACK_L    = 4'd8,
    ACT_BACK_R    = 4'd9,
    ACT_FWD_PWM   = 4'd10
  } drive_act_e;

  typedef enum logic [1:0] {
    DRV_MANUAL = 2'd0,
    DRV_FOLLOW = 2'd1,
    DRV_AVOID  = 2'd2
  } drive_mode_e;

endpackage

[sv/rdm_if.sv]
// ----------------------------------------------------------------------------
// rdm_if: channel interfaces of the drive mode controller
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface rdm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  command_code;
  logic [9:0]  obstacle_cm;
  logic [11:0] line_pos_q8;
  logic [31:0] now_ms;

  modport source (output valid, kind, command_code, obstacle_cm, line_pos_q8, now_ms,
                  input ready);
  modport sink   (input valid, kind, command_code, obstacle_cm, line_pos_q8, now_ms,
                  output ready);
endinterface

interface rdm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] drive_action;
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic [1:0] current_mode;

  modport source (output valid, drive_action, left_speed, right_speed, current_mode,
                  input ready);
  modport sink   (input valid, drive_action, left_speed, right_speed, current_mode,
                  output ready);
endinterface

interface rdm_cfg_if;
  import rdm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

[sv/rdm_steer.sv]
// ----------------------------------------------------------------------------
// rdm_steer: proportional line steering
// Turns the line position into a turn term and clamps both wheel PWMs.
// ----------------------------------------------------------------------------
module rdm_steer #(
  parameter int unsigned LINE_SENSORS = rdm_pkg::LINE_SENSORS_DEF
) (
  input  logic [7:0]  base_speed_i,
  input  logic [15:0] steer_gain_q8_i,
  input  logic [7:0]  min_speed_i,
  input  logic [7:0]  max_speed_i,
  input  logic [11:0] line_pos_q8_i,
  output logic [7:0]  left_speed_o,
  output logic [7:0]  right_speed_o
);

  localparam logic [12:0] CENTER = 13'((LINE_SENSORS - 1) * 128);

  logic signed [12:0] err;
  logic signed [29:0] prod;
  logic        [29:0] mag;
  logic signed [14:0] turn;
  logic signed [14:0] base_s;
  logic signed [14:0] left_raw;
  logic signed [14:0] right_raw;

  function automatic logic [7:0] clamp_pwm(input logic signed [14:0] v,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic signed [14:0] lo_s;
    logic signed [14:0] hi_s;
    lo_s = $signed({7'd0, lo});
    hi_s = $signed({7'd0, hi});
    if (v < lo_s) return lo;
    if (v > hi_s) return hi;
    return v[7:0];
  endfunction

  always_comb begin
    err    = $signed({1'b0, line_pos_q8_i} - CENTER);
    prod   = 30'($signed({1'b0, steer_gain_q8_i})) * 30'(err);
    mag    = prod[29] ? 30'(-prod) : 30'(prod);
    // The turn truncates toward zero: shift the magnitude, then restore the sign.
    turn   = prod[29] ? -$signed({1'b0, mag[29:16]}) : $signed({1'b0, mag[29:16]});
    base_s = $signed({7'd0, base_speed_i});
    left_raw  = base_s - turn;
    right_raw = base_s + turn;
  end

  assign left_speed_o  = clamp_pwm(left_raw, min_speed_i, max_speed_i);
  assign right_speed_o = clamp_pwm(right_raw, min_speed_i, max_speed_i);

endmodule

[sv/robot_drive_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// robot_drive_mode_controller_unit: drive mode controller of a two-motor car
// Takes command bytes and control ticks and answers one drive action each.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one item per handshake: a command byte (kind 0) or a
//          control tick with distance, line position and time (kind 1).
//   out_o  returns exactly one result item per input item, in order: the
//          drive action, the wheel PWMs (zero unless the action is fwd PWM)
//          and the mode after the item.
//   cfg_i  writes one of eight registers by index; ready is always high.
//          Write only while no item is in flight.
// Timing: an item is captured in the input register, evaluated in one pass
//   of logic and lands in the result register, which offers it on out_o.
//   One item per cycle is sustained while out_o is taken; the single 16 x 13
//   multiply of the steering path sets the cycle.
// A stalled receiver holds the result register; the input register keeps
//   one more item and then in_i.ready drops until out_o is taken.
// Reset clears mode, direction flags, avoidance phase and deadline, and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module robot_drive_mode_controller_unit #(
  parameter int unsigned LINE_SENSORS = rdm_pkg::LINE_SENSORS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdm_in_if.sink    in_i,
  rdm_out_if.source out_o,
  rdm_cfg_if.sink   cfg_i
);

  import rdm_pkg::*;

  typedef enum logic [1:0] {
    PH_CRUISE = 2'd0,
    PH_BACKUP = 2'd1,
    PH_TURN   = 2'd2
  } avoid_phase_e;

  // Configuration registers.
  logic [7:0]  base_speed_q, min_speed_q, max_speed_q;
  logic [15:0] steer_gain_q, backup_ms_q, turn_ms_q;
  logic [9:0]  line_stop_q, avoid_trig_q;

  // Input register.
  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [7:0]  s1_code_q;
  logic [9:0]  s1_dist_q;
  logic [11:0] s1_pos_q;
  logic [31:0] s1_now_q;

  // Controller state.
  drive_mode_e  mode_q, mode_d;
  logic         fwd_q, fwd_d, bwd_q, bwd_d, left_q, left_d, right_q, right_d;
  avoid_phase_e phase_q, phase_d;
  logic [31:0]  deadline_q, deadline_d;

  // Result register.
  logic        out_valid_q;
  drive_act_e  act_q, act_d;
  logic [7:0]  ls_q, ls_d, rs_q, rs_d;
  drive_mode_e res_mode_q;

  logic        advance;
  logic        in_accept;
  logic [7:0]  code_lc;
  logic [7:0]  steer_ls, steer_rs;
  logic        near_line, near_avoid, reached;
  drive_act_e  manual_act;

  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  rdm_steer #(
    .LINE_SENSORS(LINE_SENSORS)
  ) u_steer (
    .base_speed_i   (base_speed_q),
    .steer_gain_q8_i(steer_gain_q),
    .min_speed_i    (min_speed_q),
    .max_speed_i    (max_speed_q),
    .line_pos_q8_i  (s1_pos_q),
    .left_speed_o   (steer_ls),
    .right_speed_o  (steer_rs)
  );

  always_comb begin
    code_lc = (s1_code_q >= CHAR_UP_A && s1_code_q <= CHAR_UP_Z) ?
              s1_code_q + CASE_DELTA : s1_code_q;
    near_line  = (s1_dist_q != 10'd0) && (s1_dist_q < line_stop_q);
    near_avoid = (s1_dist_q != 10'd0) && (s1_dist_q < avoid_trig_q);
    reached    = s1_now_q >= deadline_q;

    if (fwd_q) begin
      manual_act = left_q ? ACT_FWD_L : (right_q ? ACT_FWD_R : ACT_FWD);
    end else if (bwd_q) begin
      manual_act = left_q ? ACT_BACK_L : (right_q ? ACT_BACK_R : ACT_BACK);
    end else begin
      manual_act = left_q ? ACT_SPIN_L : (right_q ? ACT_SPIN_R : ACT_STOP);
    end
  end

  always_comb begin
    act_d      = ACT_NONE;
    ls_d       = 8'd0;
    rs_d       = 8'd0;
    mode_d     = mode_q;
    fwd_d      = fwd_q;
    bwd_d      = bwd_q;
    left_d     = left_q;
    right_d    = right_q;
    phase_d    = phase_q;
    deadline_d = deadline_q;

    if (s1_kind_q == KIND_CMD) begin
      case (code_lc)
        CMD_MANUAL, CMD_LINE, CMD_PROX: begin
          mode_d  = (code_lc == CMD_MANUAL) ? DRV_MANUAL :
                    (code_lc == CMD_LINE) ? DRV_FOLLOW : DRV_AVOID;
          fwd_d   = 1'b0;
          bwd_d   = 1'b0;
          left_d  = 1'b0;
          right_d = 1'b0;
          phase_d = PH_CRUISE;
          act_d   = ACT_STOP;
        end
        CMD_FWD: begin
          fwd_d = !fwd_q;
          bwd_d = 1'b0;
        end
        CMD_BACK: begin
          bwd_d = !bwd_q;
          fwd_d = 1'b0;
        end
        CMD_LEFT: begin
          left_d  = !left_q;
          right_d = 1'b0;
        end
        CMD_RIGHT: begin
          right_d = !right_q;
          left_d  = 1'b0;
        end
        CMD_CLEAR: begin
          fwd_d   = 1'b0;
          bwd_d   = 1'b0;
          left_d  = 1'b0;
          right_d = 1'b0;
          act_d   = ACT_STOP;
        end
        default: act_d = ACT_NONE;
      endcase
    end else begin
      case (mode_q)
        DRV_MANUAL: act_d = manual_act;
        DRV_FOLLOW: begin
          if (near_line) begin
            act_d = ACT_STOP;
          end else begin
            act_d = ACT_FWD_PWM;
            ls_d  = steer_ls;
            rs_d  = steer_rs;
          end
        end
        DRV_AVOID: begin
          case (phase_q)
            PH_CRUISE: begin
              if (near_avoid) begin
                phase_d    = PH_BACKUP;
                deadline_d = s1_now_q + {16'd0, backup_ms_q};
                act_d      = ACT_BACK;
              end else begin
                act_d = ACT_FWD;
              end
            end
            PH_BACKUP: begin
              if (reached) begin
                phase_d    = PH_TURN;
                deadline_d = s1_now_q + {16'd0, turn_ms_q};
                act_d      = ACT_SPIN_L;
              end
            end
            PH_TURN: begin
              if (reached) phase_d = PH_CRUISE;
            end
            default: phase_d = PH_CRUISE;
          endcase
        end
        default: act_d = ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= RST_BASE_SPEED;
      steer_gain_q <= RST_STEER_GAIN;
      min_speed_q  <= RST_MIN_SPEED;
      max_speed_q  <= RST_MAX_SPEED;
      line_stop_q  <= RST_LINE_STOP_CM;
      avoid_trig_q <= RST_AVOID_TRIG_CM;
      backup_ms_q  <= RST_BACKUP_MS;
      turn_ms_q    <= RST_TURN_MS;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASE_SPEED:    base_speed_q <= cfg_i.wdata[7:0];
        CFG_STEER_GAIN:    steer_gain_q <= cfg_i.wdata;
        CFG_MIN_SPEED:     min_speed_q  <= cfg_i.wdata[7:0];
        CFG_MAX_SPEED:     max_speed_q  <= cfg_i.wdata[7:0];
        CFG_LINE_STOP_CM:  line_stop_q  <= cfg_i.wdata[9:0];
        CFG_AVOID_TRIG_CM: avoid_trig_q <= cfg_i.wdata[9:0];
        CFG_BACKUP_MS:     backup_ms_q  <= cfg_i.wdata;
        CFG_TURN_MS:       turn_ms_q    <= cfg_i.wdata;
        default:           base_speed_q <= base_speed_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= in_i.kind;
      s1_code_q <= in_i.command_code;
      s1_dist_q <= in_i.obstacle_cm;
      s1_pos_q  <= in_i.line_pos_q8;
      s1_now_q  <= in_i.now_ms;
    end
  end

  // State moves on only when the item in the input register is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= DRV_MANUAL;
      fwd_q      <= 1'b0;
      bwd_q      <= 1'b0;
      left_q     <= 1'b0;
      right_q    <= 1'b0;
      phase_q    <= PH_CRUISE;
      deadline_q <= 32'd0;
    end else if (advance) begin
      mode_q     <= mode_d;
      fwd_q      <= fwd_d;
      bwd_q      <= bwd_d;
      left_q     <= left_d;
      right_q    <= right_d;
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act_q      <= act_d;
      ls_q       <= ls_d;
      rs_q       <= rs_d;
      res_mode_q <= mode_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_action = act_q;
  assign out_o.left_speed   = ls_q;
  assign out_o.right_speed  = rs_q;
  assign out_o.current_mode = res_mode_q;

  // Avoidance phases only run in proximity mode.
  a_phase_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_CRUISE) |-> (mode_q == DRV_AVOID))
    else $error("avoidance phase active outside proximity mode");

  // Opposing direction flags are exclusive.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_q && bwd_q) && !(left_q && right_q))
    else $error("opposing direction flags both set");

  // A PWM result only comes from line follow mode.
  a_pwm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && act_q == ACT_FWD_PWM) |-> (res_mode_q == DRV_FOLLOW))
    else $error("PWM action outside line follow mode");

  // Wheel speeds are zero unless the action is fwd PWM.
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && act_q != ACT_FWD_PWM) |-> (ls_q == 8'd0 && rs_q == 8'd0))
    else $error("wheel speeds set on a non-PWM action");

  // An item held in the input register is not dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("pending item lost from the input register");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression of robot_drive_mode_controller_unit
// Drives command bytes and control ticks through the item channel, writes the
// register file between phases, and checks every drive result in order
// against a cycle-free model of the controller kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  import rdm_pkg::*;

  localparam logic KIND_TICK   = 1'b1;
  localparam int   LINE_CENTER = (LINE_SENSORS_DEF - 1) * 128;
  localparam int   DRAIN_LIMIT = 20000;
  localparam int   TIMEOUT     = 3_000_000;

  typedef enum logic [1:0] {
    PH_CRUISE = 2'd0,
    PH_BACKUP = 2'd1,
    PH_TURN   = 2'd2
  } avoid_phase_e;

  typedef struct packed {
    logic [3:0] act;
    logic [7:0] left;
    logic [7:0] right;
    logic [1:0] mode;
  } drive_res_t;

  typedef struct {
    logic        kind;
    logic [7:0]  code;
    logic [9:0]  obst;
    logic [11:0] pos;
    logic [31:0] now;
    bit          typed;
    drive_res_t  res;
  } drive_item_t;

  logic clk;
  logic rst_n;
  bit   idle_on;

  rdm_in_if  in_ch ();
  rdm_out_if out_ch ();
  rdm_cfg_if cfg_ch ();

  robot_drive_mode_controller_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Model copy of the register file.
  logic [7:0]  m_base, m_min, m_max;
  logic [15:0] m_gain, m_backup, m_turn;
  logic [9:0]  m_stop_cm, m_trig_cm;

  // Model copy of the controller state.
  drive_mode_e  m_mode;
  bit           fl_fwd, fl_back, fl_left, fl_right;
  avoid_phase_e m_phase;
  logic [31:0]  m_deadline;

  drive_res_t  expected_drives [$];
  drive_item_t directed_rows [$];
  logic [31:0] sim_ms;
  int          mismatches;
  int          items_sent;
  int          results_checked;
  int          writes_done;
  bit          seen_act [16];

  logic [7:0] letters [8] = '{CMD_MANUAL, CMD_LINE, CMD_PROX, CMD_FWD,
                              CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_CLEAR};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("robot_drive_mode_controller_unit regression: fail");
    $finish;
  end

  function automatic logic [7:0] clamp_pwm(int v);
    int lo;
    int hi;
    lo = m_min;
    hi = m_max;
    if (v < lo) return m_min;
    if (v > hi) return m_max;
    return v[7:0];
  endfunction

  // Advances the model by one item and returns the drive result it gives.
  function automatic drive_res_t compute_drive(drive_item_t it);
    drive_res_t r;
    logic [7:0] c;
    longint     gain_l, err_l, prod, mag;
    int         turn, base;
    r = '0;
    r.act = ACT_NONE;
    if (it.kind == KIND_CMD) begin
      c = it.code;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c + CASE_DELTA;
      case (c)
        CMD_MANUAL, CMD_LINE, CMD_PROX: begin
          if (c == CMD_MANUAL) m_mode = DRV_MANUAL;
          else if (c == CMD_LINE) m_mode = DRV_FOLLOW;
          else m_mode = DRV_AVOID;
          {fl_fwd, fl_back, fl_left, fl_right} = '0;
          m_phase = PH_CRUISE;
          r.act = ACT_STOP;
        end
        CMD_FWD: begin
          fl_fwd = !fl_fwd;
          fl_back = 1'b0;
        end
        CMD_BACK: begin
          fl_back = !fl_back;
          fl_fwd = 1'b0;
        end
        CMD_LEFT: begin
          fl_left = !fl_left;
          fl_right = 1'b0;
        end
        CMD_RIGHT: begin
          fl_right = !fl_right;
          fl_left = 1'b0;
        end
        CMD_CLEAR: begin
          {fl_fwd, fl_back, fl_left, fl_right} = '0;
          r.act = ACT_STOP;
        end
        default: ;
      endcase
    end else begin
      case (m_mode)
        DRV_MANUAL: begin
          if (fl_fwd) r.act = fl_left ? ACT_FWD_L : (fl_right ? ACT_FWD_R : ACT_FWD);
          else if (fl_back) r.act = fl_left ? ACT_BACK_L : (fl_right ? ACT_BACK_R : ACT_BACK);
          else r.act = fl_left ? ACT_SPIN_L : (fl_right ? ACT_SPIN_R : ACT_STOP);
        end
        DRV_FOLLOW: begin
          if (it.obst > 0 && it.obst < m_stop_cm) begin
            r.act = ACT_STOP;
          end else begin
            gain_l = m_gain;
            err_l = it.pos;
            err_l = err_l - LINE_CENTER;
            prod = gain_l * err_l;
            // The turn term truncates toward zero, so shift the magnitude.
            mag = (prod < 0) ? -prod : prod;
            turn = int'(mag >>> 16);
            if (prod < 0) turn = -turn;
            base = m_base;
            r.left = clamp_pwm(base - turn);
            r.right = clamp_pwm(base + turn);
            r.act = ACT_FWD_PWM;
          end
        end
        DRV_AVOID: begin
          case (m_phase)
            PH_CRUISE: begin
              if (it.obst > 0 && it.obst < m_trig_cm) begin
                m_phase = PH_BACKUP;
                m_deadline = it.now + m_backup;
                r.act = ACT_BACK;
              end else begin
                r.act = ACT_FWD;
              end
            end
            PH_BACKUP: begin
              if (it.now >= m_deadline) begin
                m_phase = PH_TURN;
                m_deadline = it.now + m_turn;
                r.act = ACT_SPIN_L;
              end
            end
            PH_TURN: begin
              if (it.now >= m_deadline) m_phase = PH_CRUISE;
            end
            default: m_phase = PH_CRUISE;
          endcase
        end
        default: ;
      endcase
    end
    r.mode = m_mode;
    return r;
  endfunction

  function automatic drive_item_t random_drive_item();
    drive_item_t it;
    int          roll;
    it.kind = ($urandom_range(0, 99) >= 12) ? KIND_TICK : KIND_CMD;
    it.code = 8'($urandom_range(0, 255));
    if (it.kind == KIND_CMD && $urandom_range(0, 99) < 85) begin
      it.code = letters[$urandom_range(0, 7)];
      if ($urandom_range(0, 1) == 1) it.code = it.code - CASE_DELTA;
    end
    roll = $urandom_range(0, 99);
    if (roll < 25) it.obst = '0;
    else if (roll < 60) it.obst = 10'($urandom_range(1, 60));
    else it.obst = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) < 7) it.pos = 12'($urandom_range(0, 3840));
    else it.pos = 12'(LINE_CENTER - 64 + $urandom_range(0, 128));
    if (it.kind == KIND_TICK) begin
      // Ticks carry a mostly steady clock so that avoidance deadlines expire.
      sim_ms = sim_ms + $urandom_range(0, 300);
      if ($urandom_range(0, 49) == 0) sim_ms = $urandom;
      it.now = sim_ms;
    end else begin
      it.now = $urandom;
    end
    it.typed = 1'b0;
    it.res = '0;
    return it;
  endfunction

  task automatic add_row(logic kind, logic [7:0] code, logic [9:0] obst, logic [11:0] pos,
                         logic [31:0] now, bit typed, drive_act_e act, logic [7:0] ls,
                         logic [7:0] rs, drive_mode_e mode);
    drive_item_t row;
    row.kind = kind;
    row.code = code;
    row.obst = obst;
    row.pos = pos;
    row.now = now;
    row.typed = typed;
    row.res.act = act;
    row.res.left = ls;
    row.res.right = rs;
    row.res.mode = mode;
    directed_rows.push_back(row);
  endtask

  // Called right after a rising edge; returns at the edge that takes the item.
  task automatic send_drive_item(drive_item_t it);
    drive_res_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.command_code <= it.code;
    in_ch.obstacle_cm <= it.obst;
    in_ch.line_pos_q8 <= it.pos;
    in_ch.now_ms <= it.now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = compute_drive(it);
    if (it.typed) want = it.res;
    expected_drives.push_back(want);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_BASE_SPEED:    m_base = val[7:0];
      CFG_STEER_GAIN:    m_gain = val;
      CFG_MIN_SPEED:     m_min = val[7:0];
      CFG_MAX_SPEED:     m_max = val[7:0];
      CFG_LINE_STOP_CM:  m_stop_cm = val[9:0];
      CFG_AVOID_TRIG_CM: m_trig_cm = val[9:0];
      CFG_BACKUP_MS:     m_backup = val;
      CFG_TURN_MS:       m_turn = val;
      default: ;
    endcase
    writes_done++;
  endtask

  // Profile 1 is all maxima, 2 all zeros, 3 a crossed PWM clamp, 6 the reset
  // values; the others are random within working ranges.
  task automatic load_profile(int sel);
    logic [15:0] v [8];
    case (sel)
      1: v = '{16'd255, 16'hFFFF, 16'd255, 16'd255, 16'd1023, 16'd1023, 16'hFFFF, 16'hFFFF};
      2: v = '{default: 16'd0};
      3: v = '{16'd128, 16'd20000, 16'd200, 16'd50, 16'd100, 16'd100, 16'd50, 16'd50};
      6: v = '{16'(RST_BASE_SPEED), RST_STEER_GAIN, 16'(RST_MIN_SPEED), 16'(RST_MAX_SPEED),
               16'(RST_LINE_STOP_CM), 16'(RST_AVOID_TRIG_CM), RST_BACKUP_MS, RST_TURN_MS};
      default: begin
        v[0] = 16'($urandom_range(0, 255));
        v[1] = 16'($urandom_range(0, 65535));
        v[2] = 16'($urandom_range(0, 120));
        v[3] = 16'($urandom_range(130, 255));
        v[4] = 16'($urandom_range(0, 200));
        v[5] = 16'($urandom_range(0, 200));
        v[6] = 16'($urandom_range(0, 800));
        v[7] = 16'($urandom_range(0, 800));
      end
    endcase
    write_reg(CFG_BASE_SPEED, v[0]);
    write_reg(CFG_STEER_GAIN, v[1]);
    write_reg(CFG_MIN_SPEED, v[2]);
    write_reg(CFG_MAX_SPEED, v[3]);
    write_reg(CFG_LINE_STOP_CM, v[4]);
    write_reg(CFG_AVOID_TRIG_CM, v[5]);
    write_reg(CFG_BACKUP_MS, v[6]);
    write_reg(CFG_TURN_MS, v[7]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle(int settle);
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_drives.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result receiver with random stall bursts.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    drive_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_act[out_ch.drive_action] = 1'b1;
      if (expected_drives.size() == 0) begin
        flag_mismatch("unexpected result, action", -1, out_ch.drive_action);
      end else begin
        want = expected_drives.pop_front();
        results_checked++;
        if (out_ch.drive_action !== want.act)
          flag_mismatch("drive_action", want.act, out_ch.drive_action);
        if (out_ch.left_speed !== want.left)
          flag_mismatch("left_speed", want.left, out_ch.left_speed);
        if (out_ch.right_speed !== want.right)
          flag_mismatch("right_speed", want.right, out_ch.right_speed);
        if (out_ch.current_mode !== want.mode)
          flag_mismatch("current_mode", want.mode, out_ch.current_mode);
      end
    end
  end

  initial begin : stimulus
    int acts_hit;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_CMD;
    in_ch.command_code <= '0;
    in_ch.obstacle_cm <= '0;
    in_ch.line_pos_q8 <= '0;
    in_ch.now_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;
    m_base = RST_BASE_SPEED;
    m_gain = RST_STEER_GAIN;
    m_min = RST_MIN_SPEED;
    m_max = RST_MAX_SPEED;
    m_stop_cm = RST_LINE_STOP_CM;
    m_trig_cm = RST_AVOID_TRIG_CM;
    m_backup = RST_BACKUP_MS;
    m_turn = RST_TURN_MS;
    m_mode = DRV_MANUAL;
    {fl_fwd, fl_back, fl_left, fl_right} = '0;
    m_phase = PH_CRUISE;
    m_deadline = '0;
    sim_ms = '0;

    // Manual flags, both letter cases, unknown byte.
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd0, 1, ACT_STOP, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_FWD, 10'd0, 12'd0, 32'd0, 1, ACT_NONE, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_LEFT - CASE_DELTA, 10'd0, 12'd0, 32'd0, 1, ACT_NONE, 0, 0,
            DRV_MANUAL);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd0, 1, ACT_FWD_L, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_RIGHT, 10'd0, 12'd0, 32'd0, 1, ACT_NONE, 0, 0, DRV_MANUAL);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd0, 1, ACT_FWD_R, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_BACK - CASE_DELTA, 10'd0, 12'd0, 32'd0, 1, ACT_NONE, 0, 0,
            DRV_MANUAL);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd0, 1, ACT_BACK_R, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_CLEAR - CASE_DELTA, 10'd0, 12'd0, 32'd0, 1, ACT_STOP, 0, 0,
            DRV_MANUAL);
    add_row(KIND_CMD, 8'hFF, 10'h3FF, 12'd3840, 32'hFFFF_FFFF, 1, ACT_NONE, 0, 0,
            DRV_MANUAL);
    add_row(KIND_CMD, CMD_LEFT, 10'd0, 12'd0, 32'd0, 1, ACT_NONE, 0, 0, DRV_MANUAL);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd0, 1, ACT_SPIN_L, 0, 0, DRV_MANUAL);
    // Line follow: obstacle stop, centered line, both extremes of position.
    add_row(KIND_CMD, CMD_LINE - CASE_DELTA, 10'd0, 12'd0, 32'd0, 1, ACT_STOP, 0, 0,
            DRV_FOLLOW);
    add_row(KIND_TICK, 8'd0, 10'd10, 12'd512, 32'd0, 1, ACT_STOP, 0, 0, DRV_FOLLOW);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd512, 32'd0, 1, ACT_FWD_PWM, 140, 140, DRV_FOLLOW);
    add_row(KIND_TICK, 8'd0, 10'd1023, 12'd0, 32'd0, 1, ACT_FWD_PWM, 210, 90, DRV_FOLLOW);
    add_row(KIND_TICK, 8'd0, 10'd25, 12'd3840, 32'd0, 1, ACT_FWD_PWM, 90, 255, DRV_FOLLOW);
    // Proximity: back up, wait, turn, return to cruising, deadline wrap.
    add_row(KIND_CMD, CMD_PROX, 10'd0, 12'd0, 32'd0, 1, ACT_STOP, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd1000, 1, ACT_FWD, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd5, 12'd0, 32'd1000, 1, ACT_BACK, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd1399, 1, ACT_NONE, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd1400, 1, ACT_SPIN_L, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'd1700, 1, ACT_NONE, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd19, 12'd0, 32'hFFFF_FF00, 1, ACT_BACK, 0, 0, DRV_AVOID);
    add_row(KIND_TICK, 8'd0, 10'd0, 12'd0, 32'hFFFF_FFFF, 0, ACT_NONE, 0, 0, DRV_MANUAL);
    add_row(KIND_CMD, CMD_MANUAL - CASE_DELTA, 10'd0, 12'd0, 32'd0, 1, ACT_STOP, 0, 0,
            DRV_MANUAL);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    foreach (directed_rows[i]) send_drive_item(directed_rows[i]);
    repeat (100) send_drive_item(random_drive_item());

    for (int ph = 1; ph <= 6; ph++) begin
      wait_idle(4);
      load_profile(ph);
      // The second setting and the closing one run without any idling.
      idle_on = (ph != 2 && ph != 6);
      @(posedge clk);
      repeat (120) send_drive_item(random_drive_item());
    end

    wait_idle(10);
    if (expected_drives.size() != 0)
      flag_mismatch("missing results, count", 0, expected_drives.size());

    acts_hit = 0;
    for (int a = 0; a <= ACT_FWD_PWM; a++) acts_hit += seen_act[a];
    $display("Sent %0d items and %0d register writes over 7 settings; %0d results checked.",
             items_sent, writes_done, results_checked);
    $display("Drive actions seen: %0d of 11; mismatches: %0d.", acts_hit, mismatches);
    if (mismatches == 0) begin
      $display("robot_drive_mode_controller_unit regression: pass");
    end else begin
      $display("robot_drive_mode_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
